>>> rtl/fst_pkg.sv
// Package for the format string tokenizer: phase and error codes, the result record,
// character constants and small decode functions.
// No dependencies; the top level and the bench import it.
package fst_pkg;

  // Default sizing of the block.
  localparam int unsigned POS_BITS_DEF  = 16;
  localparam int unsigned DIGIT_MAX_DEF = 99;

  // Depth of the result queue and saturation limit of parsed numbers.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam logic [15:0] NUM_SAT    = 16'hFFFF;

  // Bytes from 0200 (octal) upwards are not ASCII.
  localparam logic [7:0] CH_NON_ASCII = 8'h80;

  // Characters that the parser reacts to.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;

  // Bit positions in the flag field, in the order "-+ #0".
  localparam int unsigned FLAG_MINUS = 0;
  localparam int unsigned FLAG_PLUS  = 1;
  localparam int unsigned FLAG_SPACE = 2;
  localparam int unsigned FLAG_HASH  = 3;
  localparam int unsigned FLAG_ZERO  = 4;

  // Size modifier codes.
  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_H    = 2'd1;
  localparam logic [1:0] SIZE_L    = 2'd2;

  // Precision value that means no dot was given.
  localparam logic signed [16:0] PREC_NONE = -17'sd1;

  // Parse phases, one-hot.
  typedef enum logic [9:0] {
    PH_LIT    = 10'b00_0000_0001,
    PH_PCT    = 10'b00_0000_0010,
    PH_ARGN   = 10'b00_0000_0100,
    PH_FLAGS  = 10'b00_0000_1000,
    PH_WIDTH  = 10'b00_0001_0000,
    PH_AFTERW = 10'b00_0010_0000,
    PH_DOT    = 10'b00_0100_0000,
    PH_PREC   = 10'b00_1000_0000,
    PH_SIZE   = 10'b01_0000_0000,
    PH_CONV   = 10'b10_0000_0000
  } phase_e;

  // Error codes of a result record.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EARLY_END = 3'd1,
    ERR_NON_ASCII = 3'd2,
    ERR_BAD_CONV  = 3'd3,
    ERR_TOO_LONG  = 3'd4
  } err_e;

  // One result record.
  typedef struct packed {
    logic [15:0]        text_start;
    logic [15:0]        text_length;
    logic [6:0]         converter;
    logic [15:0]        arg_number;
    logic [4:0]         flag_bits;
    logic [15:0]        min_width;
    logic signed [16:0] precision;
    logic [1:0]         size_modifier;
    logic               forwards_precision;
    err_e               error_code;
    logic               last_of_run;
  } rec_t;

  // Converters accepted: integer group "dic", "ouxX", float group "feEgG", strings "sS".
  function automatic logic is_conv(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      8'h64, 8'h69, 8'h63,                 // d i c
      8'h6F, 8'h75, 8'h78, 8'h58,          // o u x X
      8'h66, 8'h65, 8'h45, 8'h67, 8'h47,   // f e E g G
      8'h73, 8'h53:                        // s S
        hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Plus overrides space, and then space overrides zero.
  function automatic logic [4:0] resolve_flags(input logic [4:0] f);
    logic [4:0] r;
    r = f;
    if (r[FLAG_SPACE] && r[FLAG_PLUS]) r[FLAG_SPACE] = 1'b0;
    if (r[FLAG_ZERO] && r[FLAG_SPACE]) r[FLAG_ZERO] = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/fst_byte_if.sv
// Channel carrying format string bytes into the tokenizer.
// Stand-alone interface; no dependencies.
interface fst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] fmt_byte;
  logic       end_of_string;

  modport source (output valid, fmt_byte, end_of_string, input ready);
  modport sink   (input valid, fmt_byte, end_of_string, output ready);
endinterface

>>> rtl/fst_rec_if.sv
// Channel carrying the tokenizer's result records.
// Stand-alone interface; no dependencies.
interface fst_rec_if;
  logic               valid;
  logic               ready;
  logic [15:0]        text_start;
  logic [15:0]        text_length;
  logic [6:0]         converter;
  logic [15:0]        arg_number;
  logic [4:0]         flag_bits;
  logic [15:0]        min_width;
  logic signed [16:0] precision;
  logic [1:0]         size_modifier;
  logic               forwards_precision;
  logic [2:0]         error_code;
  logic               last_of_run;

  modport source (output valid, text_start, text_length, converter, arg_number, flag_bits,
                  min_width, precision, size_modifier, forwards_precision, error_code,
                  last_of_run, input ready);
  modport sink   (input valid, text_start, text_length, converter, arg_number, flag_bits,
                  min_width, precision, size_modifier, forwards_precision, error_code,
                  last_of_run, output ready);
endinterface

>>> rtl/format_spec_tokenizer.sv
// Top level of the printf-style format string tokenizer.
// Depends on fst_pkg, fst_byte_if and fst_rec_if.
//
//   Channel | Direction | Request carries                           | Accepted when
//   in_i    | sink      | fmt_byte, end_of_string                   | valid && ready
//   out_o   | source    | one spec record (text, arg, flags, ...)   | valid && ready
//
// Each byte is parsed in the cycle it is accepted; one byte per cycle is sustained unless the queue backs up.
// Records enter a four-entry queue whose head drives out_o, so a record can appear the
// cycle after its byte. A byte may give two records (a star record and an error record).
// in_i.ready is low only while fewer than two queue slots are free.
// Reset is asynchronous and needs no clearing pass; the final byte of a string also
// returns the parser to its reset state.
module format_spec_tokenizer #(
  parameter int unsigned POS_BITS  = fst_pkg::POS_BITS_DEF,
  parameter int unsigned DIGIT_MAX = fst_pkg::DIGIT_MAX_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  fst_byte_if.sink   in_i,
  fst_rec_if.source  out_o
);
  import fst_pkg::*;

  localparam int unsigned DC_BITS  = $clog2(DIGIT_MAX + 1);
  localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Parser state.
  phase_e              phase_q, phase_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] lit_start_q, lit_start_d;
  logic [POS_BITS-1:0] held_ts_q, held_ts_d;
  logic [POS_BITS-1:0] held_tl_q, held_tl_d;
  logic [15:0]         run_arg_q, run_arg_d;
  logic [15:0]         dig_val_q, dig_val_d;
  logic [DC_BITS-1:0]  dig_cnt_q, dig_cnt_d;
  logic                lead_zero_q, lead_zero_d;
  logic [4:0]          flags_q, flags_d;
  logic [15:0]         width_q, width_d;
  logic signed [16:0]  prec_q, prec_d;
  logic [1:0]          size_q, size_d;
  logic [15:0]         spec_arg_q, spec_arg_d;
  logic                err_hold_q, err_hold_d;

  // Result queue.
  rec_t                fifo_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] cnt_q;

  // Per-byte working signals.
  logic        in_fire, out_fire, eos, is_dig, dig_ovf, active;
  logic [7:0]  c;
  logic [3:0]  dig;
  logic [19:0] prod;
  logic [15:0] dig_next;
  err_e        err;
  logic        emit_v;
  rec_t        emit_rec, err_rec, rec0, rec1;
  logic [1:0]  push_n;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign c        = in_i.fmt_byte;
  assign eos      = in_i.end_of_string;
  assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig      = c[3:0];

  // Next digit value when a run continues, saturated at the largest number.
  assign prod     = {1'b0, dig_val_q, 3'b000} + {3'b000, dig_val_q, 1'b0} + {16'd0, dig};
  assign dig_next = (prod[19:16] != 4'd0) ? NUM_SAT : prod[15:0];
  assign dig_ovf  = (dig_cnt_q >= DC_BITS'(DIGIT_MAX));

  // Single pass over the phases. Fall-through only ever moves forward in this order,
  // so each phase is one block that may hand the byte on to a later one.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    lit_start_d = lit_start_q;
    held_ts_d   = held_ts_q;
    held_tl_d   = held_tl_q;
    run_arg_d   = run_arg_q;
    dig_val_d   = dig_val_q;
    dig_cnt_d   = dig_cnt_q;
    lead_zero_d = lead_zero_q;
    flags_d     = flags_q;
    width_d     = width_q;
    prec_d      = prec_q;
    size_d      = size_q;
    spec_arg_d  = spec_arg_q;
    err_hold_d  = err_hold_q;
    err         = ERR_NONE;
    active      = 1'b0;
    emit_v      = 1'b0;
    emit_rec    = '0;

    if (in_fire && !err_hold_q) begin
      active = 1'b1;

      // Any non-ASCII byte inside a spec is an error.
      if (phase_q != PH_LIT && c >= CH_NON_ASCII) begin
        err    = ERR_NON_ASCII;
        active = 1'b0;
      end

      // Literal text: a percent opens a spec; the final byte closes the trailing text.
      if (active && phase_d == PH_LIT) begin
        if (c == CH_PERCENT) begin
          held_ts_d = lit_start_d;
          held_tl_d = pos_q - lit_start_d;
          phase_d   = PH_PCT;
        end else if (eos) begin
          emit_v               = 1'b1;
          emit_rec.text_start  = 16'(lit_start_d);
          emit_rec.text_length = 16'(pos_q + POS_BITS'(1) - lit_start_d);
        end
        active = 1'b0;
      end

      // Just after the percent sign.
      if (active && phase_d == PH_PCT) begin
        if (c == CH_PERCENT) begin
          emit_v               = 1'b1;
          emit_rec.text_start  = 16'(held_ts_d);
          emit_rec.text_length = 16'(held_tl_d);
          emit_rec.converter   = CH_PERCENT[6:0];
          held_ts_d            = '0;
          held_tl_d            = '0;
          lit_start_d          = pos_q + POS_BITS'(1);
          phase_d              = PH_LIT;
          active               = 1'b0;
        end else if (is_dig) begin
          dig_val_d   = {12'd0, dig};
          dig_cnt_d   = DC_BITS'(1);
          lead_zero_d = (c == CH_ZERO);
          phase_d     = PH_ARGN;
          active      = 1'b0;
        end else begin
          if (run_arg_d != NUM_SAT) run_arg_d = run_arg_d + 16'd1;
          spec_arg_d = run_arg_d;
          phase_d    = PH_FLAGS;
        end
      end

      // Digits that may turn out to be a positional argument number.
      if (active && phase_d == PH_ARGN) begin
        if (is_dig) begin
          if (dig_ovf) begin
            err = ERR_TOO_LONG;
          end else begin
            dig_val_d = dig_next;
            dig_cnt_d = dig_cnt_q + DC_BITS'(1);
          end
          active = 1'b0;
        end else if (c == CH_DOLLAR && dig_val_q != 16'd0) begin
          run_arg_d  = dig_val_q;
          spec_arg_d = dig_val_q;
          phase_d    = PH_FLAGS;
          active     = 1'b0;
        end else begin
          // Not positional: read the digits again as zero flag and width.
          if (run_arg_d != NUM_SAT) run_arg_d = run_arg_d + 16'd1;
          spec_arg_d = run_arg_d;
          if (lead_zero_q) flags_d[FLAG_ZERO] = 1'b1;
          if (dig_val_q == 16'd0) begin
            phase_d = PH_FLAGS;
          end else begin
            width_d = dig_val_q;
            phase_d = PH_AFTERW;
          end
        end
      end

      // Flag characters, a star width or the first width digit.
      if (active && phase_d == PH_FLAGS) begin
        active = 1'b0;
        case (c)
          CH_MINUS: flags_d[FLAG_MINUS] = 1'b1;
          CH_PLUS:  flags_d[FLAG_PLUS]  = 1'b1;
          CH_SPACE: flags_d[FLAG_SPACE] = 1'b1;
          CH_HASH:  flags_d[FLAG_HASH]  = 1'b1;
          CH_ZERO:  flags_d[FLAG_ZERO]  = 1'b1;
          CH_STAR: begin
            emit_v               = 1'b1;
            emit_rec.text_start  = 16'(held_ts_d);
            emit_rec.text_length = 16'(held_tl_d);
            emit_rec.converter   = CH_STAR[6:0];
            emit_rec.arg_number  = spec_arg_d;
            emit_rec.flag_bits   = resolve_flags(flags_d);
            emit_rec.min_width   = width_d;
            emit_rec.size_modifier = size_d;
            flags_d   = '0;
            width_d   = '0;
            prec_d    = PREC_NONE;
            size_d    = SIZE_NONE;
            held_ts_d = '0;
            held_tl_d = '0;
            if (run_arg_d != NUM_SAT) run_arg_d = run_arg_d + 16'd1;
            spec_arg_d = run_arg_d;
            phase_d    = PH_AFTERW;
          end
          default: begin
            if (is_dig) begin
              dig_val_d = {12'd0, dig};
              dig_cnt_d = DC_BITS'(1);
              phase_d   = PH_WIDTH;
            end else begin
              width_d = '0;
              phase_d = PH_AFTERW;
              active  = 1'b1;
            end
          end
        endcase
      end

      // Width digits.
      if (active && phase_d == PH_WIDTH) begin
        if (is_dig) begin
          if (dig_ovf) begin
            err = ERR_TOO_LONG;
          end else begin
            dig_val_d = dig_next;
            dig_cnt_d = dig_cnt_q + DC_BITS'(1);
          end
          active = 1'b0;
        end else begin
          width_d = dig_val_q;
          phase_d = PH_AFTERW;
        end
      end

      // After the width: a dot opens the precision.
      if (active && phase_d == PH_AFTERW) begin
        if (c == CH_DOT) begin
          phase_d = PH_DOT;
          active  = 1'b0;
        end else begin
          prec_d  = PREC_NONE;
          phase_d = PH_SIZE;
        end
      end

      // Just after the dot.
      if (active && phase_d == PH_DOT) begin
        if (c == CH_STAR) begin
          emit_v                      = 1'b1;
          emit_rec.text_start         = 16'(held_ts_d);
          emit_rec.text_length        = 16'(held_tl_d);
          emit_rec.converter          = CH_STAR[6:0];
          emit_rec.arg_number         = spec_arg_d;
          emit_rec.flag_bits          = resolve_flags(flags_d);
          emit_rec.min_width          = width_d;
          emit_rec.size_modifier      = size_d;
          emit_rec.forwards_precision = 1'b1;
          flags_d   = '0;
          width_d   = '0;
          prec_d    = '0;
          size_d    = SIZE_NONE;
          held_ts_d = '0;
          held_tl_d = '0;
          if (run_arg_d != NUM_SAT) run_arg_d = run_arg_d + 16'd1;
          spec_arg_d = run_arg_d;
          phase_d    = PH_SIZE;
          active     = 1'b0;
        end else if (is_dig) begin
          dig_val_d = {12'd0, dig};
          dig_cnt_d = DC_BITS'(1);
          phase_d   = PH_PREC;
          active    = 1'b0;
        end else begin
          prec_d  = '0;
          phase_d = PH_SIZE;
        end
      end

      // Precision digits.
      if (active && phase_d == PH_PREC) begin
        if (is_dig) begin
          if (dig_ovf) begin
            err = ERR_TOO_LONG;
          end else begin
            dig_val_d = dig_next;
            dig_cnt_d = dig_cnt_q + DC_BITS'(1);
          end
          active = 1'b0;
        end else begin
          prec_d  = {1'b0, dig_val_q};
          phase_d = PH_SIZE;
        end
      end

      // Optional h or l modifier.
      if (active && phase_d == PH_SIZE) begin
        phase_d = PH_CONV;
        if (c == CH_LOWER_H) begin
          size_d = SIZE_H;
          active = 1'b0;
        end else if (c == CH_LOWER_L) begin
          size_d = SIZE_L;
          active = 1'b0;
        end
      end

      // Converter byte closes the spec.
      if (active && phase_d == PH_CONV) begin
        if (is_conv(c)) begin
          emit_v                 = 1'b1;
          emit_rec.text_start    = 16'(held_ts_d);
          emit_rec.text_length   = 16'(held_tl_d);
          emit_rec.converter     = c[6:0];
          emit_rec.arg_number    = spec_arg_d;
          emit_rec.flag_bits     = resolve_flags(flags_d);
          emit_rec.min_width     = width_d;
          emit_rec.precision     = prec_d;
          emit_rec.size_modifier = size_d;
          flags_d     = '0;
          width_d     = '0;
          prec_d      = PREC_NONE;
          size_d      = SIZE_NONE;
          held_ts_d   = '0;
          held_tl_d   = '0;
          lit_start_d = pos_q + POS_BITS'(1);
          phase_d     = PH_LIT;
        end else begin
          err = ERR_BAD_CONV;
        end
        active = 1'b0;
      end

      // A string that ends inside a spec is cut short.
      if (err == ERR_NONE && eos && phase_d != PH_LIT) err = ERR_EARLY_END;
      if (err != ERR_NONE) err_hold_d = 1'b1;
      pos_d = pos_q + POS_BITS'(1);
    end

    // The final byte returns everything to the reset state.
    if (in_fire && eos) begin
      phase_d     = PH_LIT;
      pos_d       = '0;
      lit_start_d = '0;
      held_ts_d   = '0;
      held_tl_d   = '0;
      run_arg_d   = '0;
      dig_val_d   = '0;
      dig_cnt_d   = '0;
      lead_zero_d = 1'b0;
      flags_d     = '0;
      width_d     = '0;
      prec_d      = PREC_NONE;
      size_d      = SIZE_NONE;
      spec_arg_d  = '0;
      err_hold_d  = 1'b0;
    end
  end

  // Order the records of this byte and mark the last one.
  always_comb begin
    err_rec            = '0;
    err_rec.error_code = err;
    rec0               = '0;
    rec1               = '0;
    push_n             = 2'd0;
    if (emit_v) begin
      rec0   = emit_rec;
      push_n = 2'd1;
    end
    if (err != ERR_NONE) begin
      if (emit_v) begin
        rec1   = err_rec;
        push_n = 2'd2;
      end else begin
        rec0   = err_rec;
        push_n = 2'd1;
      end
    end
    if (push_n == 2'd1) rec0.last_of_run = 1'b1;
    if (push_n == 2'd2) rec1.last_of_run = 1'b1;
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LIT;
      pos_q       <= '0;
      lit_start_q <= '0;
      held_ts_q   <= '0;
      held_tl_q   <= '0;
      run_arg_q   <= '0;
      dig_val_q   <= '0;
      dig_cnt_q   <= '0;
      lead_zero_q <= 1'b0;
      flags_q     <= '0;
      width_q     <= '0;
      prec_q      <= PREC_NONE;
      size_q      <= SIZE_NONE;
      spec_arg_q  <= '0;
      err_hold_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      lit_start_q <= lit_start_d;
      held_ts_q   <= held_ts_d;
      held_tl_q   <= held_tl_d;
      run_arg_q   <= run_arg_d;
      dig_val_q   <= dig_val_d;
      dig_cnt_q   <= dig_cnt_d;
      lead_zero_q <= lead_zero_d;
      flags_q     <= flags_d;
      width_q     <= width_d;
      prec_q      <= prec_d;
      size_q      <= size_d;
      spec_arg_q  <= spec_arg_d;
      err_hold_q  <= err_hold_d;
    end
  end

  // Result queue storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= rec0;
    if (push_n == 2'd2) fifo_q[wr_ptr_q + PTR_BITS'(1)] <= rec1;
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
      if (out_fire) rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      cnt_q <= cnt_q + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
    end
  end

  // A new byte is taken while two slots are free.
  assign in_i.ready = (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));

  // Queue head drives the output channel.
  assign out_o.valid              = (cnt_q != '0);
  assign out_o.text_start         = fifo_q[rd_ptr_q].text_start;
  assign out_o.text_length        = fifo_q[rd_ptr_q].text_length;
  assign out_o.converter          = fifo_q[rd_ptr_q].converter;
  assign out_o.arg_number         = fifo_q[rd_ptr_q].arg_number;
  assign out_o.flag_bits          = fifo_q[rd_ptr_q].flag_bits;
  assign out_o.min_width          = fifo_q[rd_ptr_q].min_width;
  assign out_o.precision          = fifo_q[rd_ptr_q].precision;
  assign out_o.size_modifier      = fifo_q[rd_ptr_q].size_modifier;
  assign out_o.forwards_precision = fifo_q[rd_ptr_q].forwards_precision;
  assign out_o.error_code         = fifo_q[rd_ptr_q].error_code;
  assign out_o.last_of_run        = fifo_q[rd_ptr_q].last_of_run;

  // The queue never holds more records than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // Bytes after an error give no record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && err_hold_q) |-> (push_n == 2'd0))
    else $error("record produced while an error is held");

  // Two records from one byte are always a star record and an early end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (rec0.converter == CH_STAR[6:0] &&
                          rec1.error_code == ERR_EARLY_END))
    else $error("unexpected record pair");

  // Plus and space never leave the block together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> !(rec0.flag_bits[FLAG_PLUS] && rec0.flag_bits[FLAG_SPACE]))
    else $error("flag conflict left unresolved");

  // The final byte of a string leaves the parser in its reset phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eos) |=> (phase_q == PH_LIT && !err_hold_q && pos_q == '0))
    else $error("parser not returned to idle after end of string");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for format_spec_tokenizer: format strings in, spec records out.
// Uses fst_pkg, fst_byte_if, fst_rec_if and format_spec_tokenizer from the RTL; needs no other file.
module tb;
  import fst_pkg::*;

  localparam int unsigned DIGITS_LIMIT = DIGIT_MAX_DEF;
  localparam string       CONV_CHARS   = "dicouxXfeEgGsS";
  localparam string       FLAG_CHARS   = "-+ #0";

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         typed;
    rec_t       rec;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fst_byte_if byte_ch ();
  fst_rec_if  rec_ch ();

  format_spec_tokenizer u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (rec_ch)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirrored by the bench.
  phase_e             tok_phase;
  logic [15:0]        tok_pos;
  logic [15:0]        tok_lit_start;
  logic [15:0]        tok_run_arg;
  logic [15:0]        tok_num;
  int unsigned        tok_ndigits;
  logic               tok_lead_zero;
  logic [4:0]         tok_flags;
  logic [15:0]        tok_width;
  logic signed [16:0] tok_prec;
  logic [1:0]         tok_size;
  logic [15:0]        tok_arg;
  logic               tok_halted;
  logic [15:0]        tok_held_start;
  logic [15:0]        tok_held_len;

  rec_t       step_recs[$];
  rec_t       expected_recs[$];
  dir_row_t   dir_rows[$];
  logic [7:0] fmt_bytes[$];

  int unsigned tx_idle_pct = 36;
  int unsigned rx_idle_pct = 46;
  int unsigned n_items, n_skipped, n_strings, n_checked, n_err_recs, n_star_recs, n_fail;

  function automatic rec_t mk_rec(input logic [15:0] ts, input logic [15:0] tl,
                                  input logic [6:0] conv, input logic [15:0] arg,
                                  input logic [4:0] fl, input logic [15:0] w,
                                  input logic signed [16:0] pr, input logic [1:0] sz,
                                  input logic fwd, input err_e e, input logic lst);
    rec_t r;
    r.text_start         = ts;
    r.text_length        = tl;
    r.converter          = conv;
    r.arg_number         = arg;
    r.flag_bits          = fl;
    r.min_width          = w;
    r.precision          = pr;
    r.size_modifier      = sz;
    r.forwards_precision = fwd;
    r.error_code         = e;
    r.last_of_run        = lst;
    return r;
  endfunction

  // An error record is all zero apart from the code and the last marker.
  function automatic rec_t fault_rec(input err_e e, input logic lst);
    return mk_rec(16'd0, 16'd0, 7'd0, 16'd0, 5'd0, 16'd0, 17'sd0, SIZE_NONE, 1'b0, e, lst);
  endfunction

  function automatic void clear_open_spec();
    tok_flags      = 5'd0;
    tok_width      = 16'd0;
    tok_prec       = PREC_NONE;
    tok_size       = SIZE_NONE;
    tok_held_start = 16'd0;
    tok_held_len   = 16'd0;
  endfunction

  function automatic void reset_tokenizer();
    tok_phase     = PH_LIT;
    tok_pos       = 16'd0;
    tok_lit_start = 16'd0;
    tok_run_arg   = 16'd0;
    tok_num       = 16'd0;
    tok_ndigits   = 0;
    tok_lead_zero = 1'b0;
    tok_arg       = 16'd0;
    tok_halted    = 1'b0;
    clear_open_spec();
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit conv_ok(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < CONV_CHARS.len(); i++) begin
      if (CONV_CHARS[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  // Plus wins over space, then space wins over zero.
  function automatic logic [4:0] settle_flags(input logic [4:0] f);
    logic [4:0] r;
    r = f;
    if (r[FLAG_SPACE] && r[FLAG_PLUS]) r[FLAG_SPACE] = 1'b0;
    if (r[FLAG_ZERO] && r[FLAG_SPACE]) r[FLAG_ZERO] = 1'b0;
    return r;
  endfunction

  // Accumulates one decimal digit; refuses once the digit budget is spent.
  function automatic bit push_digit(input logic [7:0] c);
    logic [31:0] v;
    if (tok_ndigits >= DIGITS_LIMIT) return 1'b0;
    tok_ndigits++;
    v = 32'(tok_num) * 32'd10 + 32'(c - CH_ZERO);
    if (v > 32'(NUM_SAT)) v = 32'(NUM_SAT);
    tok_num = v[15:0];
    return 1'b1;
  endfunction

  function automatic void start_number(input logic [7:0] c);
    tok_num     = 16'd0;
    tok_ndigits = 0;
    void'(push_digit(c));
  endfunction

  function automatic void next_arg();
    if (tok_run_arg != NUM_SAT) tok_run_arg++;
    tok_arg = tok_run_arg;
  endfunction

  function automatic rec_t star_rec(input logic fwd);
    return mk_rec(tok_held_start, tok_held_len, CH_STAR[6:0], tok_arg, settle_flags(tok_flags),
                  tok_width, 17'sd0, tok_size, fwd, ERR_NONE, 1'b0);
  endfunction

  // Parses one byte and leaves the records it causes in step_recs.
  task automatic tokenize_byte(input logic [7:0] c, input logic eos, output bit skipped);
    logic [15:0] pos;
    err_e        err;
    bit          again;
    rec_t        r;
    skipped = tok_halted;
    step_recs.delete();
    if (tok_halted) begin
      if (eos) reset_tokenizer();
      return;
    end
    pos   = tok_pos;
    err   = ERR_NONE;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      if (tok_phase != PH_LIT && c >= CH_NON_ASCII) begin
        err = ERR_NON_ASCII;
        break;
      end
      case (tok_phase)
        PH_LIT: begin
          if (c == CH_PERCENT) begin
            tok_held_start = tok_lit_start;
            tok_held_len   = pos - tok_lit_start;
            tok_phase      = PH_PCT;
          end else if (eos) begin
            step_recs.push_back(mk_rec(tok_lit_start, pos + 16'd1 - tok_lit_start, 7'd0,
                                       16'd0, 5'd0, 16'd0, 17'sd0, SIZE_NONE, 1'b0,
                                       ERR_NONE, 1'b0));
          end
        end
        PH_PCT: begin
          if (c == CH_PERCENT) begin
            step_recs.push_back(mk_rec(tok_held_start, tok_held_len, CH_PERCENT[6:0], 16'd0,
                                       5'd0, 16'd0, 17'sd0, SIZE_NONE, 1'b0, ERR_NONE,
                                       1'b0));
            tok_held_start = 16'd0;
            tok_held_len   = 16'd0;
            tok_lit_start  = pos + 16'd1;
            tok_phase      = PH_LIT;
          end else if (is_dec(c)) begin
            tok_lead_zero = (c == CH_ZERO);
            start_number(c);
            tok_phase = PH_ARGN;
          end else begin
            next_arg();
            tok_phase = PH_FLAGS;
            again     = 1'b1;
          end
        end
        PH_ARGN: begin
          if (is_dec(c)) begin
            if (!push_digit(c)) err = ERR_TOO_LONG;
          end else if (c == CH_DOLLAR && tok_num != 16'd0) begin
            tok_run_arg = tok_num;
            tok_arg     = tok_num;
            tok_phase   = PH_FLAGS;
          end else begin
            // Not a positional index: leading zero becomes a flag, the rest a width.
            next_arg();
            if (tok_lead_zero) tok_flags[FLAG_ZERO] = 1'b1;
            if (tok_num == 16'd0) begin
              tok_phase = PH_FLAGS;
            end else begin
              tok_width = tok_num;
              tok_phase = PH_AFTERW;
            end
            again = 1'b1;
          end
        end
        PH_FLAGS: begin
          if (c == CH_MINUS) tok_flags[FLAG_MINUS] = 1'b1;
          else if (c == CH_PLUS) tok_flags[FLAG_PLUS] = 1'b1;
          else if (c == CH_SPACE) tok_flags[FLAG_SPACE] = 1'b1;
          else if (c == CH_HASH) tok_flags[FLAG_HASH] = 1'b1;
          else if (c == CH_ZERO) tok_flags[FLAG_ZERO] = 1'b1;
          else if (c == CH_STAR) begin
            step_recs.push_back(star_rec(1'b0));
            clear_open_spec();
            next_arg();
            tok_phase = PH_AFTERW;
          end else if (is_dec(c)) begin
            start_number(c);
            tok_phase = PH_WIDTH;
          end else begin
            tok_width = 16'd0;
            tok_phase = PH_AFTERW;
            again     = 1'b1;
          end
        end
        PH_WIDTH: begin
          if (is_dec(c)) begin
            if (!push_digit(c)) err = ERR_TOO_LONG;
          end else begin
            tok_width = tok_num;
            tok_phase = PH_AFTERW;
            again     = 1'b1;
          end
        end
        PH_AFTERW: begin
          if (c == CH_DOT) begin
            tok_phase = PH_DOT;
          end else begin
            tok_prec  = PREC_NONE;
            tok_phase = PH_SIZE;
            again     = 1'b1;
          end
        end
        PH_DOT: begin
          if (c == CH_STAR) begin
            step_recs.push_back(star_rec(1'b1));
            clear_open_spec();
            tok_prec = 17'sd0;
            next_arg();
            tok_phase = PH_SIZE;
          end else if (is_dec(c)) begin
            start_number(c);
            tok_phase = PH_PREC;
          end else begin
            tok_prec  = 17'sd0;
            tok_phase = PH_SIZE;
            again     = 1'b1;
          end
        end
        PH_PREC: begin
          if (is_dec(c)) begin
            if (!push_digit(c)) err = ERR_TOO_LONG;
          end else begin
            tok_prec  = signed'({1'b0, tok_num});
            tok_phase = PH_SIZE;
            again     = 1'b1;
          end
        end
        PH_SIZE: begin
          if (c == CH_LOWER_H) begin
            tok_size  = SIZE_H;
            tok_phase = PH_CONV;
          end else if (c == CH_LOWER_L) begin
            tok_size  = SIZE_L;
            tok_phase = PH_CONV;
          end else begin
            tok_phase = PH_CONV;
            again     = 1'b1;
          end
        end
        default: begin
          if (!conv_ok(c)) begin
            err = ERR_BAD_CONV;
            break;
          end
          step_recs.push_back(mk_rec(tok_held_start, tok_held_len, c[6:0], tok_arg,
                                     settle_flags(tok_flags), tok_width, tok_prec, tok_size,
                                     1'b0, ERR_NONE, 1'b0));
          clear_open_spec();
          tok_lit_start = pos + 16'd1;
          tok_phase     = PH_LIT;
        end
      endcase
    end
    if (err == ERR_NONE && eos && tok_phase != PH_LIT) err = ERR_EARLY_END;
    if (err != ERR_NONE) begin
      step_recs.push_back(fault_rec(err, 1'b0));
      tok_halted = 1'b1;
    end
    if (step_recs.size() != 0) begin
      r = step_recs.pop_back();
      r.last_of_run = 1'b1;
      step_recs.push_back(r);
    end
    if (eos) reset_tokenizer();
    else tok_pos = pos + 16'd1;
  endtask

  // Drives one byte from a falling edge and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                           input rec_t typed_rec);
    bit skipped;
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.fmt_byte      <= b;
    byte_ch.end_of_string <= eos;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tokenize_byte(b, eos, skipped);
    n_items++;
    if (skipped) n_skipped++;
    if (typed) expected_recs.push_back(typed_rec);
    else foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
    @(negedge clk);
  endtask

  task automatic send_format();
    foreach (fmt_bytes[i]) send_byte(fmt_bytes[i], i == fmt_bytes.size() - 1, 1'b0, '0);
    n_strings++;
  endtask

  // Holds the sender off until every outstanding record has come back.
  task automatic drain_records();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_recs.size() != 0) @(negedge clk);
  endtask

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) fmt_bytes.push_back(s[i]);
  endfunction

  function automatic void put_num(input int unsigned v);
    put_text($sformatf("%0d", v));
  endfunction

  // A digit run right at or just past the digit budget.
  function automatic void put_digit_run();
    int unsigned n;
    n = $urandom_range(DIGITS_LIMIT, DIGITS_LIMIT + 3);
    fmt_bytes.push_back("1");
    repeat (n - 1) fmt_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic logic [7:0] lit_byte();
    logic [7:0] b;
    if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
    else b = 8'($urandom_range(8'h20, 8'h7E));
    if (b == CH_PERCENT) b = "a";
    return b;
  endfunction

  function automatic void put_saturating();
    case ($urandom_range(2))
      0:       put_num(65535);
      1:       put_num(65536);
      default: put_num(99999);
    endcase
  endfunction

  // One conversion spec, mostly well formed with random content.
  function automatic void put_spec();
    int unsigned r;
    fmt_bytes.push_back(CH_PERCENT);
    if ($urandom_range(99) < 8) begin
      fmt_bytes.push_back(CH_PERCENT);
      return;
    end
    r = $urandom_range(99);
    if (r < 18) begin
      put_num($urandom_range(1, 20));
      fmt_bytes.push_back(CH_DOLLAR);
    end else if (r < 20) begin
      put_saturating();
      fmt_bytes.push_back(CH_DOLLAR);
    end else if (r < 22) begin
      put_text("0$");
    end else if (r < 23) begin
      put_digit_run();
    end
    repeat ($urandom_range(0, 3)) fmt_bytes.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
    r = $urandom_range(99);
    if (r >= 30) begin
      if (r < 42) fmt_bytes.push_back(CH_STAR);
      else if (r < 44) put_digit_run();
      else if (r < 48) put_saturating();
      else put_num($urandom_range(1, 999));
    end
    if ($urandom_range(99) >= 40) begin
      fmt_bytes.push_back(CH_DOT);
      r = $urandom_range(99);
      if (r >= 15) begin
        if (r < 30) fmt_bytes.push_back(CH_STAR);
        else if (r < 33) put_digit_run();
        else if (r < 40) put_saturating();
        else put_num($urandom_range(0, 999));
      end
    end
    r = $urandom_range(99);
    if (r >= 50) fmt_bytes.push_back(r < 75 ? CH_LOWER_H : CH_LOWER_L);
    if ($urandom_range(99) < 94) fmt_bytes.push_back(CONV_CHARS[$urandom_range(0, 13)]);
    else fmt_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // A whole format string: plain noise, or specs mixed with text, sometimes cut short.
  function automatic void gen_format();
    int unsigned r, keep;
    fmt_bytes.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 12)) begin
        fmt_bytes.push_back($urandom_range(2) == 0 ? CH_PERCENT : 8'($urandom_range(255)));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 5)) fmt_bytes.push_back(lit_byte());
        put_spec();
      end
      if ($urandom_range(1) == 1) begin
        repeat ($urandom_range(1, 5)) fmt_bytes.push_back(lit_byte());
      end
      if (r < 16) begin
        keep = $urandom_range(1, fmt_bytes.size());
        while (fmt_bytes.size() > keep) void'(fmt_bytes.pop_back());
      end
    end
  endfunction

  task automatic random_formats(input int unsigned target);
    while (n_items < target) begin
      gen_format();
      send_format();
    end
  endtask

  function automatic void add_row(input logic [7:0] b, input logic eos, input bit typed,
                                  input rec_t rec);
    dir_row_t row;
    row.b     = b;
    row.eos   = eos;
    row.typed = typed;
    row.rec   = rec;
    dir_rows.push_back(row);
  endfunction

  function automatic string rec_text(input rec_t r);
    return $sformatf({"ts=%0d tl=%0d conv=%02h arg=%0d flags=%05b width=%0d prec=%0d ",
                      "size=%0d fwd=%0b err=%0d last=%0b"},
                     r.text_start, r.text_length, r.converter, r.arg_number, r.flag_bits,
                     r.min_width, r.precision, r.size_modifier, r.forwards_precision,
                     r.error_code, r.last_of_run);
  endfunction

  function automatic string field_diffs(input rec_t a, input rec_t b);
    string s;
    s = "";
    if (a.text_start !== b.text_start) s = {s, " text_start"};
    if (a.text_length !== b.text_length) s = {s, " text_length"};
    if (a.converter !== b.converter) s = {s, " converter"};
    if (a.arg_number !== b.arg_number) s = {s, " arg_number"};
    if (a.flag_bits !== b.flag_bits) s = {s, " flag_bits"};
    if (a.min_width !== b.min_width) s = {s, " min_width"};
    if (a.precision !== b.precision) s = {s, " precision"};
    if (a.size_modifier !== b.size_modifier) s = {s, " size_modifier"};
    if (a.forwards_precision !== b.forwards_precision) s = {s, " forwards_precision"};
    if (a.error_code !== b.error_code) s = {s, " error_code"};
    if (a.last_of_run !== b.last_of_run) s = {s, " last_of_run"};
    return s;
  endfunction

  // Record sink back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) rec_ch.ready <= 1'b0;
    else rec_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Each record taken is matched against the oldest outstanding one.
  always @(posedge clk) begin : rec_check
    rec_t  got;
    rec_t  want;
    string diffs;
    if (rst_n && rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
      got = mk_rec(rec_ch.text_start, rec_ch.text_length, rec_ch.converter,
                   rec_ch.arg_number, rec_ch.flag_bits, rec_ch.min_width, rec_ch.precision,
                   rec_ch.size_modifier, rec_ch.forwards_precision,
                   err_e'(rec_ch.error_code), rec_ch.last_of_run);
      if (expected_recs.size() == 0) begin
        n_fail++;
        $display("%0t: record with nothing outstanding: %s", $time, rec_text(got));
      end else begin
        want = expected_recs.pop_front();
        n_checked++;
        if (want.error_code != ERR_NONE) n_err_recs++;
        if (want.converter == CH_STAR[6:0]) n_star_recs++;
        diffs = field_diffs(want, got);
        if (diffs != "") begin
          n_fail++;
          $display("%0t: record mismatch in%s\n  expected %s\n  actual   %s",
                   $time, diffs, rec_text(want), rec_text(got));
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("%0t: run did not complete, %0d records outstanding", $time,
             expected_recs.size());
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    byte_ch.valid         = 1'b0;
    byte_ch.fmt_byte      = 8'd0;
    byte_ch.end_of_string = 1'b0;
    reset_tokenizer();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: extreme bytes, every flag, both stars, sizes and three error kinds.
    add_row(8'hFF, 1'b1, 1'b1, mk_rec(16'd0, 16'd1, 7'd0, 16'd0, 5'd0, 16'd0, 17'sd0,
                                      SIZE_NONE, 1'b0, ERR_NONE, 1'b1));
    add_row(CH_PERCENT, 1'b0, 1'b0, '0);
    add_row(CH_PERCENT, 1'b1, 1'b1, mk_rec(16'd0, 16'd0, CH_PERCENT[6:0], 16'd0, 5'd0,
                                           16'd0, 17'sd0, SIZE_NONE, 1'b0, ERR_NONE, 1'b1));
    add_row(CH_PERCENT, 1'b0, 1'b0, '0);
    add_row(CH_MINUS, 1'b0, 1'b0, '0);
    add_row(CH_PLUS, 1'b0, 1'b0, '0);
    add_row(CH_SPACE, 1'b0, 1'b0, '0);
    add_row(CH_HASH, 1'b0, 1'b0, '0);
    add_row(CH_ZERO, 1'b0, 1'b0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, '0);
    add_row(CH_DOT, 1'b0, 1'b0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, '0);
    add_row(CH_LOWER_L, 1'b0, 1'b0, '0);
    add_row("d", 1'b1, 1'b0, '0);
    add_row(CH_PERCENT, 1'b0, 1'b0, '0);
    add_row(CH_NON_ASCII, 1'b1, 1'b1, fault_rec(ERR_NON_ASCII, 1'b1));
    add_row(CH_PERCENT, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, fault_rec(ERR_BAD_CONV, 1'b1));
    add_row(CH_PERCENT, 1'b1, 1'b1, fault_rec(ERR_EARLY_END, 1'b1));
    add_row(CH_PERCENT, 1'b0, 1'b0, '0);
    add_row("2", 1'b0, 1'b0, '0);
    add_row(CH_DOLLAR, 1'b0, 1'b0, '0);
    add_row(CH_LOWER_H, 1'b0, 1'b0, '0);
    add_row("x", 1'b1, 1'b0, '0);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].rec);
    end

    // Random strings under three idling patterns, fully drained between them.
    random_formats(433);
    drain_records();
    tx_idle_pct = 46;
    rx_idle_pct = 36;
    random_formats(866);
    drain_records();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_formats(1300);

    drain_records();
    repeat (20) @(posedge clk);
    $display("Covered %0d bytes in %0d strings (%0d ignored after an error); %0d records checked,",
             n_items, n_strings, n_skipped, n_checked);
    $display("of which %0d error records and %0d star records.", n_err_recs, n_star_recs);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
